@@ rtl/tilt_compensated_heading_top_macros.svh @@
// assertion macros for the tilt compensated heading block
// expects aclk and aresetn in the scope of use
`ifndef TILT_COMPENSATED_HEADING_TOP_MACROS_SVH
`define TILT_COMPENSATED_HEADING_TOP_MACROS_SVH

`define THC_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("thc assertion failed");

`define THC_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("thc assertion failed");

`endif

@@ rtl/thc_pkg.sv @@
// types, constants and helper functions for the tilt compensated heading block
// no dependencies
package thc_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANG_LEN       = 24;
    localparam int NSTG          = (CORDIC_STAGES < ANG_LEN) ? CORDIC_STAGES : ANG_LEN;

    localparam int CW   = 38;
    localparam int ZW   = 26;
    localparam int KW   = 26;
    localparam int GP_W = 17 + KW;

    localparam logic signed [ZW-1:0] ANG_90    = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] ROUND_ADD = ZW'(256);
    localparam logic signed [ZW-1:0] YAW_LIMIT = ZW'(23040);

    localparam logic signed [ZW-1:0] ANG_TAB [ANG_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // cordic gain in q24, from vectoring (2^24, 0)
    function automatic longint calc_kq();
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = 64'sd1 <<< 24;
        y = 0;
        for (int i = 0; i < NSTG; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
            end else begin
                x = x - dx;
                y = y + dy;
            end
        end
        return x;
    endfunction

    localparam logic signed [KW-1:0] KQ = KW'(calc_kq());

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] mag_first;
        logic signed [15:0] mag_second;
        logic signed [15:0] mag_third;
    } in_t;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic               degenerate;
    } out_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] u;
        logic signed [CW-1:0] w;
    } vec_t;

    typedef struct packed {
        logic                 degen;
        logic signed [CW-1:0] gay;
        logic signed [CW-1:0] gm0;
        logic signed [CW-1:0] gm1;
        logic signed [CW-1:0] gm2;
    } roll_sb_t;

    typedef struct packed {
        logic                 degen;
        logic signed [CW-1:0] by2k;
    } pitch_sb_t;

    localparam int SB_W  = $bits(roll_sb_t);
    localparam int PSB_W = $bits(pitch_sb_t);

    function automatic logic signed [CW-1:0] widen16(input logic signed [15:0] v);
        logic signed [CW-1:0] r;
        r = CW'(v);
        return r <<< 16;
    endfunction

    // floor(v * 2^16 * kq / 2^24)
    function automatic logic signed [CW-1:0] gain16(input logic signed [16:0] v);
        logic signed [GP_W-1:0] p;
        p = v * KQ;
        return CW'($signed(p[GP_W-1:8]));
    endfunction

endpackage

@@ rtl/thc_cordic.sv @@
// unrolled vectoring cordic with companion vector, one register per micro-rotation
// depends on thc_pkg
module thc_cordic (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ce,
    input  logic                            in_valid,
    input  thc_pkg::vec_t                   in_vec,
    input  logic [thc_pkg::SB_W-1:0]        in_sb,
    output logic                            out_valid,
    output thc_pkg::vec_t                   out_vec,
    output logic signed [thc_pkg::ZW-1:0]   out_angle,
    output logic                            out_zero,
    output logic [thc_pkg::SB_W-1:0]        out_sb
);

    logic                          v_reg    [thc_pkg::NSTG+1];
    thc_pkg::vec_t                 vec_reg  [thc_pkg::NSTG+1];
    logic signed [thc_pkg::ZW-1:0] z_reg    [thc_pkg::NSTG+1];
    logic                          zero_reg [thc_pkg::NSTG+1];
    logic [thc_pkg::SB_W-1:0]      sb_reg   [thc_pkg::NSTG+1];

    thc_pkg::vec_t                 pre_vec;
    logic signed [thc_pkg::ZW-1:0] pre_z;
    logic                          pre_zero;

    // quadrant pre-rotation
    always_comb begin
        pre_vec  = in_vec;
        pre_z    = '0;
        pre_zero = (in_vec.x == '0) && (in_vec.y == '0);
        if (in_vec.x < 0) begin
            if (in_vec.y >= 0) begin
                pre_vec.x = in_vec.y;
                pre_vec.y = -in_vec.x;
                pre_vec.u = in_vec.w;
                pre_vec.w = -in_vec.u;
                pre_z     = thc_pkg::ANG_90;
            end else begin
                pre_vec.x = -in_vec.y;
                pre_vec.y = in_vec.x;
                pre_vec.u = -in_vec.w;
                pre_vec.w = in_vec.u;
                pre_z     = -thc_pkg::ANG_90;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (ce) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            vec_reg[0]  <= pre_vec;
            z_reg[0]    <= pre_z;
            zero_reg[0] <= pre_zero;
            sb_reg[0]   <= in_sb;
        end
    end

    for (genvar i = 1; i <= thc_pkg::NSTG; i++) begin : g_stage
        logic signed [thc_pkg::CW-1:0] dx;
        logic signed [thc_pkg::CW-1:0] dy;
        logic signed [thc_pkg::CW-1:0] du;
        logic signed [thc_pkg::CW-1:0] dw;
        thc_pkg::vec_t                 vec_next;
        logic signed [thc_pkg::ZW-1:0] z_next;

        assign dx = vec_reg[i-1].y >>> (i - 1);
        assign dy = vec_reg[i-1].x >>> (i - 1);
        assign du = vec_reg[i-1].w >>> (i - 1);
        assign dw = vec_reg[i-1].u >>> (i - 1);

        always_comb begin
            vec_next = vec_reg[i-1];
            z_next   = z_reg[i-1];
            if (!zero_reg[i-1]) begin
                if (vec_reg[i-1].y >= 0) begin
                    vec_next.x = vec_reg[i-1].x + dx;
                    vec_next.y = vec_reg[i-1].y - dy;
                    vec_next.u = vec_reg[i-1].u + du;
                    vec_next.w = vec_reg[i-1].w - dw;
                    z_next     = z_reg[i-1] + thc_pkg::ANG_TAB[i-1];
                end else begin
                    vec_next.x = vec_reg[i-1].x - dx;
                    vec_next.y = vec_reg[i-1].y + dy;
                    vec_next.u = vec_reg[i-1].u - du;
                    vec_next.w = vec_reg[i-1].w + dw;
                    z_next     = z_reg[i-1] - thc_pkg::ANG_TAB[i-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (ce) begin
                v_reg[i] <= v_reg[i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                vec_reg[i]  <= vec_next;
                z_reg[i]    <= z_next;
                zero_reg[i] <= zero_reg[i-1];
                sb_reg[i]   <= sb_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[thc_pkg::NSTG];
    assign out_vec   = vec_reg[thc_pkg::NSTG];
    assign out_angle = z_reg[thc_pkg::NSTG];
    assign out_zero  = zero_reg[thc_pkg::NSTG];
    assign out_sb    = sb_reg[thc_pkg::NSTG];

endmodule

@@ rtl/tilt_compensated_heading_top.sv @@
// tilt compensated heading: roll, pitch and yaw vectoring cordic chains in one pipeline
// depends on thc_pkg, thc_cordic and tilt_compensated_heading_top_macros.svh
// the latency is set by the three unrolled cordics and the registers between them
// throughput: one request per cycle, held while m_valid is high and m_ready is low
// reset: synchronous active low aresetn clears all valid bits, data registers keep no reset
`include "tilt_compensated_heading_top_macros.svh"

module tilt_compensated_heading_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  thc_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output thc_pkg::out_t m_data
);

    localparam int LO_W = 19 + thc_pkg::KW;
    localparam int HI_W = thc_pkg::CW - 18 + thc_pkg::KW;

    logic ce;

    logic          a_valid_reg;
    thc_pkg::in_t  a_data_reg;

    logic              b_valid_reg;
    thc_pkg::vec_t     b_vec_reg;
    thc_pkg::roll_sb_t b_sb_reg;
    logic signed [16:0] nax;

    logic                          r_valid;
    thc_pkg::vec_t                 r_vec;
    logic signed [thc_pkg::ZW-1:0] r_angle;
    logic                          r_zero;
    logic [thc_pkg::SB_W-1:0]      r_sb;
    thc_pkg::roll_sb_t             rsb;

    logic               p_valid_reg;
    thc_pkg::vec_t      p_vec_reg;
    thc_pkg::pitch_sb_t p_sb_reg;
    thc_pkg::vec_t      p_vec_next;
    thc_pkg::pitch_sb_t p_sb_next;

    logic                          q_valid;
    thc_pkg::vec_t                 q_vec;
    logic signed [thc_pkg::ZW-1:0] q_angle;
    logic                          q_zero;
    logic [thc_pkg::SB_W-1:0]      q_sb;
    thc_pkg::pitch_sb_t            qsb;

    logic                          y1_valid_reg;
    logic signed [LO_W-1:0]        y1_lo_reg;
    logic signed [HI_W-1:0]        y1_hi_reg;
    logic signed [thc_pkg::CW-1:0] y1_x_reg;
    logic                          y1_degen_reg;

    logic                          y2_valid_reg;
    thc_pkg::vec_t                 y2_vec_reg;
    logic                          y2_degen_reg;
    logic signed [63:0]            y_sum;
    thc_pkg::vec_t                 y2_vec_next;

    logic                          w_valid;
    thc_pkg::vec_t                 w_vec;
    logic signed [thc_pkg::ZW-1:0] w_angle;
    logic                          w_zero;
    logic [thc_pkg::SB_W-1:0]      w_sb;

    logic signed [thc_pkg::ZW-1:0] z_round;
    logic signed [thc_pkg::ZW-1:0] q_yaw;
    logic signed [thc_pkg::ZW-1:0] yaw_clamped;

    logic          out_valid_reg;
    thc_pkg::out_t out_data_reg;
    thc_pkg::out_t out_data_next;

    assign ce      = !out_valid_reg || m_ready;
    assign s_ready = ce;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ce) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_data_reg <= s_data;
        end
    end

    // roll setup and gain products
    assign nax = -17'(a_data_reg.accel_x);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ce) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            b_vec_reg.x    <= thc_pkg::widen16(a_data_reg.accel_z);
            b_vec_reg.y    <= thc_pkg::widen16(a_data_reg.accel_y);
            b_vec_reg.u    <= thc_pkg::widen16(a_data_reg.mag_second);
            b_vec_reg.w    <= thc_pkg::widen16(a_data_reg.mag_third);
            b_sb_reg.degen <= (a_data_reg.accel_x == '0) && (a_data_reg.accel_y == '0)
                              && (a_data_reg.accel_z == '0);
            b_sb_reg.gay   <= thc_pkg::gain16(nax);
            b_sb_reg.gm0   <= thc_pkg::gain16(17'(a_data_reg.mag_first));
            b_sb_reg.gm1   <= thc_pkg::gain16(17'(a_data_reg.mag_second));
            b_sb_reg.gm2   <= thc_pkg::gain16(17'(a_data_reg.mag_third));
        end
    end

    thc_cordic u_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (b_valid_reg),
        .in_vec    (b_vec_reg),
        .in_sb     (b_sb_reg),
        .out_valid (r_valid),
        .out_vec   (r_vec),
        .out_angle (r_angle),
        .out_zero  (r_zero),
        .out_sb    (r_sb)
    );

    // pitch setup
    assign rsb = thc_pkg::roll_sb_t'(r_sb);

    always_comb begin
        p_vec_next.x    = r_vec.x;
        p_vec_next.y    = rsb.gay;
        p_vec_next.u    = rsb.gm0;
        p_vec_next.w    = r_zero ? rsb.gm1 : r_vec.u;
        p_sb_next.degen = rsb.degen;
        p_sb_next.by2k  = r_zero ? -rsb.gm2 : -r_vec.w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (ce) begin
            p_valid_reg <= r_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_vec_reg <= p_vec_next;
            p_sb_reg  <= p_sb_next;
        end
    end

    thc_cordic u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (p_valid_reg),
        .in_vec    (p_vec_reg),
        .in_sb     (thc_pkg::SB_W'(p_sb_reg)),
        .out_valid (q_valid),
        .out_vec   (q_vec),
        .out_angle (q_angle),
        .out_zero  (q_zero),
        .out_sb    (q_sb)
    );

    // gain on by2 as two partial products
    assign qsb = thc_pkg::pitch_sb_t'(q_sb[thc_pkg::PSB_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y1_valid_reg <= 1'b0;
        end else if (ce) begin
            y1_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            y1_lo_reg    <= $signed({1'b0, qsb.by2k[17:0]}) * thc_pkg::KQ;
            y1_hi_reg    <= $signed(qsb.by2k[thc_pkg::CW-1:18]) * thc_pkg::KQ;
            y1_x_reg     <= q_vec.u;
            y1_degen_reg <= qsb.degen;
        end
    end

    assign y_sum = (64'(y1_hi_reg) <<< 18) + 64'(y1_lo_reg);

    always_comb begin
        y2_vec_next.x = y1_x_reg;
        y2_vec_next.y = y_sum[thc_pkg::CW+23:24];
        y2_vec_next.u = '0;
        y2_vec_next.w = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y2_valid_reg <= 1'b0;
        end else if (ce) begin
            y2_valid_reg <= y1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            y2_vec_reg   <= y2_vec_next;
            y2_degen_reg <= y1_degen_reg;
        end
    end

    thc_cordic u_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (y2_valid_reg),
        .in_vec    (y2_vec_reg),
        .in_sb     (thc_pkg::SB_W'(y2_degen_reg)),
        .out_valid (w_valid),
        .out_vec   (w_vec),
        .out_angle (w_angle),
        .out_zero  (w_zero),
        .out_sb    (w_sb)
    );

    // angle to 1/128 degree with rounding and clamp
    assign z_round = w_angle + thc_pkg::ROUND_ADD;
    assign q_yaw   = z_round >>> 9;

    always_comb begin
        yaw_clamped = q_yaw;
        if (q_yaw > thc_pkg::YAW_LIMIT) begin
            yaw_clamped = thc_pkg::YAW_LIMIT;
        end else if (q_yaw < -thc_pkg::YAW_LIMIT) begin
            yaw_clamped = -thc_pkg::YAW_LIMIT;
        end
        out_data_next.degenerate = w_sb[0];
        out_data_next.yaw_angle  = w_sb[0] ? '0 : 16'(yaw_clamped);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= w_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `THC_ASSERT_NOW(a_degen_zero_yaw, m_valid && m_data.degenerate, m_data.yaw_angle == '0)
    `THC_ASSERT_NOW(a_yaw_range, m_valid, (m_data.yaw_angle <= 16'sd23040) && (m_data.yaw_angle >= -16'sd23040))
    `THC_ASSERT_NEXT(a_stall_holds_out, m_valid && !m_ready, m_valid && $stable(m_data) && !$past(s_ready))

endmodule
